FILE: design/n2a_pkg.sv
// shared types, codes and constants for the number to ascii formatter
// used by n2a_ctrl, n2a_dp and number_to_ascii_formatter; no dependencies
package n2a_pkg;

  // width of the hex pointer, a multiple of 4 between 16 and 64
  localparam int PointerBits = 64;

  localparam int ValueW    = 64;
  localparam int MagW      = 32;
  localparam int DecDigits = 10;
  localparam int HexDigits = PointerBits / 4;
  localparam int DigW      = 64;
  localparam int BcdLsb    = DigW - DecDigits * 4;
  localparam int HexShift  = DigW - PointerBits;
  localparam int CntW      = 5;
  localparam int CycW      = $clog2(MagW);

  // format selector codes
  localparam logic [1:0] OpSignedDec   = 2'd0;
  localparam logic [1:0] OpUnsignedDec = 2'd1;
  localparam logic [1:0] OpHexPtr      = 2'd2;

  // ascii codes
  localparam logic [7:0] ChZero     = 8'd48;
  localparam logic [7:0] ChHexAlpha = 8'd87;
  localparam logic [7:0] ChMinus    = 8'd45;
  localparam logic [7:0] ChX        = 8'd120;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ValueW-1:0] value;
  } n2a_in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } n2a_out_t;

  // which character the output shows
  typedef enum logic [1:0] {
    SEL_MINUS = 2'd0,
    SEL_ZERO  = 2'd1,
    SEL_X     = 2'd2,
    SEL_DIGIT = 2'd3
  } char_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      conv_step;
    logic      shift_dig;
    char_sel_t char_sel;
  } n2a_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] in_op;
    logic       in_neg;
    logic       conv_last;
    logic       top_zero;
    logic       cnt_one;
  } n2a_stat_t;

endpackage

FILE: design/number_to_ascii_formatter.sv
// top level of the number to ascii formatter: controller plus datapath
// depends on n2a_pkg, n2a_ctrl, n2a_dp
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid, in_stall | n2a_in_t  (operation, value)
//   out     | output    | out_valid, out_stall | n2a_out_t (char_code, last)
//
// one item at a time; in_stall is low only while the controller is idle
// decimal: load, then the minus sign when negative, then shift-and-add-3 conversion of the
// 32-bit magnitude, then leading zero skip, then up to 10 digits
// hex: load, then 2 prefix characters, then leading zero skip, then up to 16 digits
// prefix and digit characters go out one per cycle while out_stall is low
// a stalled output holds its character; reset returns the controller to idle
module number_to_ascii_formatter
  import n2a_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  n2a_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output n2a_out_t out_data
);

  n2a_cmd_t  cmd;
  n2a_stat_t stat;
  logic      last;

  n2a_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_last  (last),
    .stat      (stat),
    .cmd       (cmd)
  );

  n2a_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_last (last),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

FILE: design/n2a_dp.sv
// datapath: input latch, bit-serial binary to bcd, nibble shift register and char mux
// depends on n2a_pkg
module n2a_dp
  import n2a_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  n2a_in_t   in_data,
  input  n2a_cmd_t  cmd,
  input  logic      out_last,
  output n2a_stat_t stat,
  output n2a_out_t  out_data
);

  logic [MagW-1:0] bin_r, bin_nxt;
  logic [DigW-1:0] dig_r, dig_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CycW-1:0] cyc_r, cyc_nxt;
  logic [MagW-1:0] low32;
  logic [MagW-1:0] mag;
  logic            neg;
  logic [DecDigits*4-1:0] bcd_adj;
  logic [3:0]      top_nib;

  // input decode
  assign low32 = in_data.value[MagW-1:0];
  assign neg   = (in_data.operation == OpSignedDec) && low32[MagW-1];
  assign mag   = neg ? (~low32 + {{(MagW-1){1'b0}}, 1'b1}) : low32;

  // add-3 correction on each bcd digit ahead of the shift
  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      if (dig_r[BcdLsb + i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = dig_r[BcdLsb + i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = dig_r[BcdLsb + i*4 +: 4];
      end
    end
  end

  // next state of the working registers
  always_comb begin
    bin_nxt = bin_r;
    dig_nxt = dig_r;
    cnt_nxt = cnt_r;
    cyc_nxt = cyc_r;
    if (cmd.load) begin
      cyc_nxt = '0;
      if (in_data.operation == OpHexPtr) begin
        dig_nxt = in_data.value << HexShift;
        cnt_nxt = CntW'(HexDigits);
      end else begin
        bin_nxt = mag;
        dig_nxt = '0;
        cnt_nxt = CntW'(DecDigits);
      end
    end else if (cmd.conv_step) begin
      dig_nxt = {bcd_adj[DecDigits*4-2:0], bin_r[MagW-1], {BcdLsb{1'b0}}};
      bin_nxt = {bin_r[MagW-2:0], 1'b0};
      cyc_nxt = cyc_r + 1'b1;
    end else if (cmd.shift_dig) begin
      dig_nxt = {dig_r[DigW-5:0], 4'd0};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      cyc_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      cyc_r <= cyc_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    dig_r <= dig_nxt;
  end

  // status
  assign top_nib        = dig_r[DigW-1 -: 4];
  assign stat.in_op     = in_data.operation;
  assign stat.in_neg    = neg;
  assign stat.conv_last = (cyc_r == {CycW{1'b1}});
  assign stat.top_zero  = (top_nib == 4'd0);
  assign stat.cnt_one   = (cnt_r == CntW'(1));

  // character select
  always_comb begin
    unique case (cmd.char_sel)
      SEL_MINUS: out_data.char_code = ChMinus;
      SEL_ZERO:  out_data.char_code = ChZero;
      SEL_X:     out_data.char_code = ChX;
      SEL_DIGIT: begin
        if (top_nib < 4'd10) begin
          out_data.char_code = ChZero + {4'd0, top_nib};
        end else begin
          out_data.char_code = ChHexAlpha + {4'd0, top_nib};
        end
      end
    endcase
  end
  assign out_data.last = out_last;

endmodule

FILE: design/n2a_ctrl.sv
// controller state machine: sequences sign, prefix, conversion, zero skip and digits
// depends on n2a_pkg
module n2a_ctrl
  import n2a_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output logic      out_last,
  input  n2a_stat_t stat,
  output n2a_cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SIGN  = 7'b0000010,
    ST_CONV  = 7'b0000100,
    ST_PRE0  = 7'b0001000,
    ST_PREX  = 7'b0010000,
    ST_SKIP  = 7'b0100000,
    ST_DIGIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  assign take = !out_stall;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.conv_step = 1'b0;
    cmd.shift_dig = 1'b0;
    cmd.char_sel  = SEL_DIGIT;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    out_last      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.in_op == OpHexPtr) begin
            state_nxt = ST_PRE0;
          end else if (stat.in_neg) begin
            state_nxt = ST_SIGN;
          end else if (stat.in_op == OpUnsignedDec || stat.in_op == OpSignedDec) begin
            state_nxt = ST_CONV;
          end
        end
      end
      ST_SIGN: begin
        out_valid    = 1'b1;
        cmd.char_sel = SEL_MINUS;
        if (take) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (stat.conv_last) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_PRE0: begin
        out_valid    = 1'b1;
        cmd.char_sel = SEL_ZERO;
        if (take) begin
          state_nxt = ST_PREX;
        end
      end
      ST_PREX: begin
        out_valid    = 1'b1;
        cmd.char_sel = SEL_X;
        if (take) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros but keep the final digit
        if (stat.top_zero && !stat.cnt_one) begin
          cmd.shift_dig = 1'b1;
        end else begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        out_valid = 1'b1;
        out_last  = stat.cnt_one;
        if (take) begin
          if (stat.cnt_one) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.shift_dig = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
